>>> design/swmv_pkg.sv
`default_nettype none
package swmv_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 33;
   localparam int OUT_M_W  = 32;
   localparam int SUM_W    = 56;
   localparam int VAR_W    = 48;
   localparam int SD_W     = 24;
   localparam int OPND_W   = 36;
   localparam int PROD_W   = 2 * OPND_W;
   localparam int DVD_W    = SUM_W;
   localparam int QUO_W    = DVD_W + 1;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV_MEAN,
      ST_MUL_START,
      ST_MUL,
      ST_VAR_START,
      ST_DIV_VAR,
      ST_SQRT_START,
      ST_SQRT,
      ST_DONE
   } swmv_state_type;

   function automatic logic [MEAN_W-1:0] sat_mean(input logic [MEAN_W+24:0] v);
      logic all0;
      logic all1;
      all0 = ~|v[MEAN_W+24:MEAN_W-1];
      all1 = &v[MEAN_W+24:MEAN_W-1];
      if (all0 || all1) begin
         sat_mean = v[MEAN_W-1:0];
      end else if (v[MEAN_W+24]) begin
         sat_mean = {1'b1, {(MEAN_W-1){1'b0}}};
      end else begin
         sat_mean = {1'b0, {(MEAN_W-1){1'b1}}};
      end
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(input logic [PROD_W:0] v);
      logic all0;
      logic all1;
      all0 = ~|v[PROD_W:SUM_W-1];
      all1 = &v[PROD_W:SUM_W-1];
      if (all0 || all1) begin
         sat_sum = v[SUM_W-1:0];
      end else if (v[PROD_W]) begin
         sat_sum = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sat_sum = {1'b0, {(SUM_W-1){1'b1}}};
      end
   endfunction

   function automatic logic [VAR_W-1:0] sat_var(input logic [QUO_W-1:0] q);
      if (|q[QUO_W-1:VAR_W]) begin
         sat_var = {VAR_W{1'b1}};
      end else begin
         sat_var = q[VAR_W-1:0];
      end
   endfunction

   function automatic logic [OUT_M_W-1:0] sat_out(input logic [MEAN_W-1:0] v);
      if (v[MEAN_W-1] == v[MEAN_W-2]) begin
         sat_out = v[OUT_M_W-1:0];
      end else if (v[MEAN_W-1]) begin
         sat_out = {1'b1, {(OUT_M_W-1){1'b0}}};
      end else begin
         sat_out = {1'b0, {(OUT_M_W-1){1'b1}}};
      end
   endfunction

endpackage
`default_nettype wire

>>> design/swmv_if.sv
`default_nettype none
interface swmv_req_if;
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic signed [15:0]   sample;

   modport source (output valid, output op, output sample, input ready);
   modport sink   (input valid, input op, input sample, output ready);
endinterface

interface swmv_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   mean_value;
   logic [47:0]          variance_value;
   logic [23:0]          std_dev_value;
   logic                 window_full;

   modport source (output valid, output mean_value, output variance_value,
                   output std_dev_value, output window_full, input ready);
   modport sink   (input valid, input mean_value, input variance_value,
                   input std_dev_value, input window_full, output ready);
endinterface
`default_nettype wire

>>> design/swmv_ring.sv
`default_nettype none
module swmv_ring
   import swmv_pkg::*;
#(
   parameter int WINDOW = 64
) (
   input  wire logic                        clock,
   input  wire logic                        access,
   input  wire logic [$clog2(WINDOW)-1:0]   addr,
   input  wire logic [SAMPLE_W-1:0]         wr_data,
   output      logic [SAMPLE_W-1:0]         rd_data
);

   logic [SAMPLE_W-1:0] mem [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // read-first: the item read is the one being replaced
   always_ff @(posedge clock) begin
      if (access) begin
         mem[addr]  <= wr_data;
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/swmv_div.sv
`default_nettype none
module swmv_div
   import swmv_pkg::*;
#(
   parameter int DIVR_W = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DVD_W-1:0]   dividend,
   input  wire logic [DIVR_W-1:0]  divisor,
   output      logic               done,
   output      logic [QUO_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dvr_ff, dvr_in;
   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   diff;
   logic              ge;
   logic [QUO_W-1:0]  q_mag;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, dvr_ff};
   assign diff  = trial - {1'b0, dvr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[DVD_W-1];
         quo_in  = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         dvr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvr_ff <= dvr_in;
   end

   // floor toward minus infinity for negative dividends
   assign q_mag    = {1'b0, quo_ff};
   assign quotient = neg_ff ? (~q_mag + 1'b1 - QUO_W'(|rem_ff)) : q_mag;
   assign done     = done_ff;

endmodule
`default_nettype wire

>>> design/swmv_mul.sv
`default_nettype none
module swmv_mul
   import swmv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [OPND_W-1:0]  a,
   input  wire logic [OPND_W-1:0]  b,
   output      logic               done,
   output      logic [PROD_W-1:0]  product
);

   localparam int CNT_W = $clog2(OPND_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [OPND_W-1:0] amag_ff, amag_in;
   logic [OPND_W:0]   acc_ff, acc_in;
   logic [OPND_W-1:0] lo_ff, lo_in;
   logic [OPND_W:0]   psum;
   logic [PROD_W-1:0] p_mag;

   assign psum = acc_ff + (lo_ff[0] ? {1'b0, amag_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      amag_in = amag_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = a[OPND_W-1] ^ b[OPND_W-1];
         amag_in = a[OPND_W-1] ? (~a + 1'b1) : a;
         lo_in   = b[OPND_W-1] ? (~b + 1'b1) : b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {1'b0, psum[OPND_W:1]};
         lo_in  = {psum[0], lo_ff[OPND_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(OPND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      amag_ff <= amag_in;
      acc_ff  <= acc_in;
      lo_ff   <= lo_in;
   end

   assign p_mag   = {acc_ff[OPND_W-1:0], lo_ff};
   assign product = neg_ff ? (~p_mag + 1'b1) : p_mag;
   assign done    = done_ff;

endmodule
`default_nettype wire

>>> design/swmv_sqrt.sv
`default_nettype none
module swmv_sqrt
   import swmv_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [VAR_W-1:0]  radicand,
   output      logic              done,
   output      logic [SD_W-1:0]   root
);

   localparam int CNT_W = $clog2(SD_W);
   localparam int REM_W = SD_W + 2;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VAR_W-1:0]  val_ff, val_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SD_W-1:0]   root_ff, root_in;
   logic [REM_W+1:0]  r;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  diff;
   logic              ge;

   assign r     = {rem_ff, val_ff[VAR_W-1:VAR_W-2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign ge    = r >= trial;
   assign diff  = r - trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in  = {val_ff[VAR_W-3:0], 2'b00};
         rem_in  = ge ? diff[REM_W-1:0] : r[REM_W-1:0];
         root_in = {root_ff[SD_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

>>> design/sliding_window_mean_variance.sv
// Sliding-window mean / variance / standard deviation of signed 16-bit samples.
// req_ch carries op and sample; rsp_ch returns one item per request: the mean
// (Q.16), the sample variance (Q.16), its floor square root (Q.8) and window_full.
// op = clear zeroes all statistics and reports all-zero fields.
// Items are handled one at a time. An add item uses one shared radix-2 divider
// for the mean update and, if the sum is positive and more than one sample is
// held, again for the variance; it also uses a serial multiplier and the
// square root. A clear skips the divider and the multiplier.
// The sample ring is a single-port memory read and written in the cycle the
// item is accepted; the old sample is available in the next cycle.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following result is held back until the
// register is free. Synchronous reset clears the count, mean and sum and the
// channels; the ring needs no clearing, since an entry is only used after the
// window has been refilled.
`default_nettype none
module sliding_window_mean_variance
   import swmv_pkg::*;
#(
   parameter int WINDOW = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   swmv_req_if.sink    req_ch,
   swmv_rsp_if.source  rsp_ch
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);

   swmv_state_type        state_ff, state_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic [SAMPLE_W-1:0]   old_ff, old_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  full_ff, full_in;
   logic [MEAN_W-1:0]     mean_ff, mean_in;
   logic [MEAN_W-1:0]     prev_ff, prev_in;
   logic [OPND_W-1:0]     delta_ff, delta_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SUM_W-1:0]      good_ff, good_in;
   logic [VAR_W-1:0]      var_ff, var_in;
   logic                  rvalid_ff, rvalid_in;
   logic [OUT_M_W-1:0]    rmean_ff, rmean_in;
   logic [VAR_W-1:0]      rvar_ff, rvar_in;
   logic [SD_W-1:0]       rsd_ff, rsd_in;
   logic                  rfull_ff, rfull_in;

   logic                  accept;
   logic                  ring_access;
   logic [SAMPLE_W-1:0]   ring_rdata;
   logic                  div_start, div_done;
   logic [DVD_W-1:0]      div_dvd;
   logic [CNT_W-1:0]      div_dvr;
   logic [QUO_W-1:0]      div_q;
   logic                  mul_start, mul_done;
   logic [OPND_W-1:0]     mul_a, mul_b;
   logic [PROD_W-1:0]     mul_p;
   logic                  sqrt_start, sqrt_done;
   logic [SD_W-1:0]       sqrt_root;
   logic                  rsp_load;

   logic [SAMPLE_W-1:0]   old_src;
   logic [SAMPLE_W:0]     diff;
   logic [OPND_W-1:0]     xq, oldq, mean_x, prev_x, delta_now;
   logic [CNT_W-1:0]      denom;
   logic                  var_go;
   logic [MEAN_W+24:0]    mean_sum;
   logic [PROD_W:0]       sum_full, sum_fill;
   logic [SUM_W-1:0]      sum_full_sat;

   assign accept = req_ch.valid && req_ch.ready;

   swmv_ring #(.WINDOW(WINDOW)) u_ring (
      .clock   (clock),
      .access  (ring_access),
      .addr    (slot_ff),
      .wr_data (req_ch.sample),
      .rd_data (ring_rdata)
   );

   swmv_div #(.DIVR_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvr),
      .done     (div_done),
      .quotient (div_q)
   );

   swmv_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   swmv_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (var_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // shared arithmetic terms
   assign old_src   = (state_ff == ST_READ) ? ring_rdata : old_ff;
   assign diff      = {sample_ff[SAMPLE_W-1], sample_ff} - {old_src[SAMPLE_W-1], old_src};
   assign xq        = {{4{sample_ff[SAMPLE_W-1]}}, sample_ff, 16'h0000};
   assign oldq      = {{4{old_ff[SAMPLE_W-1]}}, old_ff, 16'h0000};
   assign mean_x    = {{(OPND_W-MEAN_W){mean_ff[MEAN_W-1]}}, mean_ff};
   assign prev_x    = {{(OPND_W-MEAN_W){prev_ff[MEAN_W-1]}}, prev_ff};
   assign delta_now = xq - mean_x;
   assign denom     = full_ff ? CNT_W'(WINDOW) : count_ff;
   assign var_go    = (denom > CNT_W'(1)) && !sum_ff[SUM_W-1] && (|sum_ff);
   assign mean_sum  = {{25{mean_ff[MEAN_W-1]}}, mean_ff} + {div_q[QUO_W-1], div_q};
   assign sum_full  = {{(PROD_W+1-SUM_W){sum_ff[SUM_W-1]}}, sum_ff} + {mul_p[PROD_W-1], mul_p};
   assign sum_fill  = {{(PROD_W+1-SUM_W){sum_ff[SUM_W-1]}}, sum_ff}
                    + {{17{mul_p[PROD_W-1]}}, mul_p[PROD_W-1:16]};
   assign sum_full_sat = sat_sum(sum_full);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_ch.op == OP_CLEAR) ? ST_VAR_START : ST_READ;
            end
         end
         ST_READ:       state_in = ST_DIV_MEAN;
         ST_DIV_MEAN:   if (div_done) state_in = ST_MUL_START;
         ST_MUL_START:  state_in = ST_MUL;
         ST_MUL:        if (mul_done) state_in = ST_VAR_START;
         ST_VAR_START:  state_in = var_go ? ST_DIV_VAR : ST_SQRT_START;
         ST_DIV_VAR:    if (div_done) state_in = ST_SQRT_START;
         ST_SQRT_START: state_in = ST_SQRT;
         ST_SQRT:       if (sqrt_done) state_in = ST_DONE;
         ST_DONE:       if (rsp_load) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ch.ready = 1'b0;
      ring_access  = 1'b0;
      div_start    = 1'b0;
      div_dvd      = '0;
      div_dvr      = '0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      sqrt_start   = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            ring_access  = req_ch.valid && (req_ch.op == OP_ADD);
         end
         ST_READ: begin
            div_start = 1'b1;
            if (full_ff) begin
               div_dvd = {{(DVD_W-SAMPLE_W-17){diff[SAMPLE_W]}}, diff, 16'h0000};
               div_dvr = CNT_W'(WINDOW);
            end else begin
               div_dvd = {{(DVD_W-OPND_W){delta_now[OPND_W-1]}}, delta_now};
               div_dvr = count_ff + 1'b1;
            end
         end
         ST_MUL_START: begin
            mul_start = 1'b1;
            if (full_ff) begin
               mul_a = xq + oldq - prev_x - mean_x;
               mul_b = {{(OPND_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff};
            end else begin
               mul_a = delta_ff;
               mul_b = delta_now;
            end
         end
         ST_VAR_START: begin
            div_start = var_go;
            div_dvd   = sum_ff;
            div_dvr   = denom - 1'b1;
         end
         ST_SQRT_START: sqrt_start = 1'b1;
         ST_DONE:       rsp_load = !rvalid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      sample_in = sample_ff;
      old_in    = old_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      full_in   = full_ff;
      mean_in   = mean_ff;
      prev_in   = prev_ff;
      delta_in  = delta_ff;
      sum_in    = sum_ff;
      good_in   = good_ff;
      var_in    = var_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.op == OP_CLEAR) begin
                  slot_in  = '0;
                  count_in = '0;
                  full_in  = 1'b0;
                  mean_in  = '0;
                  sum_in   = '0;
                  good_in  = '0;
               end else begin
                  sample_in = req_ch.sample;
                  slot_in   = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            old_in   = ring_rdata;
            prev_in  = mean_ff;
            delta_in = delta_now;
            if (!full_ff) begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_DIV_MEAN: begin
            if (div_done) begin
               mean_in = sat_mean(mean_sum);
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               if (full_ff) begin
                  // negative sum falls back to the last good one
                  if (sum_full_sat[SUM_W-1]) begin
                     sum_in = good_ff;
                  end else begin
                     sum_in  = sum_full_sat;
                     good_in = sum_full_sat;
                  end
               end else begin
                  sum_in = sat_sum(sum_fill);
                  if (count_ff == CNT_W'(WINDOW)) begin
                     full_in = 1'b1;
                  end
               end
            end
         end
         ST_VAR_START: begin
            if (!var_go) begin
               var_in = '0;
            end
         end
         ST_DIV_VAR: begin
            if (div_done) begin
               var_in = sat_var(div_q);
            end
         end
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rvalid_in = rvalid_ff;
      rmean_in  = rmean_ff;
      rvar_in   = rvar_ff;
      rsd_in    = rsd_ff;
      rfull_in  = rfull_ff;
      if (rvalid_ff && rsp_ch.ready) begin
         rvalid_in = 1'b0;
      end
      if (rsp_load) begin
         rvalid_in = 1'b1;
         rmean_in  = (count_ff != '0) ? sat_out(mean_ff) : '0;
         rvar_in   = var_ff;
         rsd_in    = sqrt_root;
         rfull_in  = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         slot_ff   <= '0;
         count_ff  <= '0;
         full_ff   <= 1'b0;
         mean_ff   <= '0;
         sum_ff    <= '0;
         good_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         count_ff  <= count_in;
         full_ff   <= full_in;
         mean_ff   <= mean_in;
         sum_ff    <= sum_in;
         good_ff   <= good_in;
         rvalid_ff <= rvalid_in;
      end
      sample_ff <= sample_in;
      old_ff    <= old_in;
      prev_ff   <= prev_in;
      delta_ff  <= delta_in;
      var_ff    <= var_in;
      rmean_ff  <= rmean_in;
      rvar_ff   <= rvar_in;
      rsd_ff    <= rsd_in;
      rfull_ff  <= rfull_in;
   end

   assign rsp_ch.valid          = rvalid_ff;
   assign rsp_ch.mean_value     = rmean_ff;
   assign rsp_ch.variance_value = rvar_ff;
   assign rsp_ch.std_dev_value  = rsd_ff;
   assign rsp_ch.window_full    = rfull_ff;

endmodule
`default_nettype wire
